[rtl/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg: shared constants for the tot to energy calibration block
// coefficient width, register map, status codes and parameter defaults
// ----------------------------------------------------------------------------
package tte_pkg;

  // coefficient registers
  localparam int COEF_W = 32;
  localparam int ADDR_W = 4;

  // parameter defaults
  localparam int TOT_BITS_DEF  = 14;
  localparam int FRAC_BITS_DEF = 16;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_T = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NEGDISC = 2'd1;
  localparam logic [1:0] ST_AZERO   = 2'd2;

endpackage

[rtl/tot_to_energy_calibration.sv]
// ----------------------------------------------------------------------------
// tot_to_energy_calibration: time-over-threshold to energy conversion
// solves tot = A*E + B - C/(E - T) for E per pixel hit, Q16.16 coefficients
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-------------------------------------
//   s_*      | in  | s_tvalid/s_tready | s_tdata: tot_count
//   m_*      | out | m_tvalid/m_tready | m_tdata: energy, m_tuser: calib_status
//   apb      | in  | psel/penable      | coef_a, coef_b, coef_c, coef_t
//
// one beat per cycle sustained while the skid stage is empty; a beat passes
// the coefficient stages, the square root pipeline (one root bit per stage),
// the numerator stage, the divider pipeline (one quotient bit per stage) and
// the output register. synchronous reset clears all valid bits; coefficients
// return to A = 1.0, B = C = T = 0. an output stall freezes the pipeline
// once a beat lands in the one-beat skid stage, which holds that beat.
// ----------------------------------------------------------------------------
module tot_to_energy_calibration import tte_pkg::*; #(
  parameter int TOT_BITS  = TOT_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((TOT_BITS+7)/8)*8-1:0]      s_tdata,   // [TOT_BITS-1:0] tot_count
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [COEF_W-1:0]                  m_tdata,   // [31:0] energy
  output logic [1:0]                         m_tuser,   // [1:0] calib_status
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ADDR_W-1:0]                  paddr,
  input  logic [COEF_W-1:0]                  pwdata,
  output logic [COEF_W-1:0]                  prdata,
  output logic                               pready
);

  // internal widths
  localparam int P_A  = 2*COEF_W - FRAC_BITS;
  localparam int P_B  = TOT_BITS + COEF_W + 1;
  localparam int P_W  = ((P_A > P_B) ? P_A : P_B) + 2;
  localparam int H_W  = (P_W + 1) / 2;
  localparam int D_W  = 2 * P_W;
  localparam int R_W  = P_W;
  localparam int N_W  = P_W + 2;
  localparam int DV_W = P_W + 1 + FRAC_BITS;
  localparam int DS_W = COEF_W + 1;
  localparam int TT_W = TOT_BITS + 1 + COEF_W;

  // coefficient registers
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_t;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= COEF_W'(1) << FRAC_BITS;
      coef_b <= '0;
      coef_c <= '0;
      coef_t <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_A:   coef_a <= pwdata;
        REG_B:   coef_b <= pwdata;
        REG_C:   coef_c <= pwdata;
        REG_T:   coef_t <= pwdata;
        default: coef_a <= coef_a;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_A:   prdata = coef_a;
      REG_B:   prdata = coef_b;
      REG_C:   prdata = coef_c;
      REG_T:   prdata = coef_t;
      default: prdata = '0;
    endcase
  end

  // values that follow from A alone
  logic [COEF_W-1:0] ua;
  logic              a_neg, a_zero;

  assign a_neg  = coef_a[COEF_W-1];
  assign a_zero = (coef_a == '0);
  assign ua     = a_neg ? (~coef_a + COEF_W'(1)) : coef_a;

  // pipeline advance
  logic en, skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // stage 1: coefficient products
  logic                     v1;
  logic [TOT_BITS-1:0]      tot1;
  logic signed [2*COEF_W-1:0] at1, bt1;
  logic signed [TT_W-1:0]   tt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot1 <= s_tdata[TOT_BITS-1:0];
      at1  <= coef_a * coef_t;
      bt1  <= coef_b * coef_t;
      tt1  <= $signed({1'b0, s_tdata[TOT_BITS-1:0]}) * coef_t;
    end
  end

  // stage 2: quadratic coefficients pB and pC
  logic                v2;
  logic signed [P_W-1:0] pb2, pc2;
  logic signed [P_W-1:0] tot_sc;

  assign tot_sc = P_W'($signed({1'b0, tot1})) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb2 <= P_W'(coef_b) - tot_sc - P_W'(at1 >>> FRAC_BITS);
      pc2 <= P_W'(tt1) - P_W'(bt1 >>> FRAC_BITS) - P_W'(coef_c);
    end
  end

  // stage 3: magnitudes
  logic                  v3;
  logic signed [P_W-1:0] pb3;
  logic [2*H_W-1:0]      mpb3, mpc3;
  logic                  pcn3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb3  <= pb2;
      mpb3 <= (2*H_W)'(pb2[P_W-1] ? (~pb2 + P_W'(1)) : pb2);
      mpc3 <= (2*H_W)'(pc2[P_W-1] ? (~pc2 + P_W'(1)) : pc2);
      pcn3 <= pc2[P_W-1];
    end
  end

  // stage 4: partial products
  logic                    v4;
  logic signed [P_W-1:0]   pb4;
  logic                    pcn4;
  logic [2*H_W-1:0]        hh4, hl4, ll4;
  logic [COEF_W+H_W-1:0]   ph4, pl4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb4  <= pb3;
      pcn4 <= pcn3;
      hh4  <= mpb3[2*H_W-1:H_W] * mpb3[2*H_W-1:H_W];
      hl4  <= mpb3[2*H_W-1:H_W] * mpb3[H_W-1:0];
      ll4  <= mpb3[H_W-1:0] * mpb3[H_W-1:0];
      ph4  <= ua * mpc3[2*H_W-1:H_W];
      pl4  <= ua * mpc3[H_W-1:0];
    end
  end

  // stage 5: pB squared and 4*A*pC
  logic                  v5;
  logic signed [P_W-1:0] pb5;
  logic                  pcn5;
  logic [D_W-1:0]        sq5, m5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb5  <= pb4;
      pcn5 <= pcn4;
      sq5  <= (D_W'(hh4) << (2*H_W)) + (D_W'(hl4) << (H_W+1)) + D_W'(ll4);
      m5   <= ((D_W'(ph4) << H_W) + D_W'(pl4)) << 2;
    end
  end

  // stage 6: discriminant
  logic                  v6;
  logic signed [P_W-1:0] pb6;
  logic                  nd6;
  logic [D_W-1:0]        d6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb6 <= pb5;
      if (a_neg != pcn5) begin
        d6  <= sq5 + m5;
        nd6 <= 1'b0;
      end else if (m5 > sq5) begin
        d6  <= '0;
        nd6 <= 1'b1;
      end else begin
        d6  <= sq5 - m5;
        nd6 <= 1'b0;
      end
    end
  end

  // square root
  logic                  sq_v;
  logic [R_W-1:0]        root;
  logic [P_W:0]          sq_side;

  tte_sqrt #(
    .D_W    (D_W),
    .R_W    (R_W),
    .SIDE_W (P_W + 1)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .d_in      (d6),
    .side_in   ({nd6, pb6}),
    .out_valid (sq_v),
    .root_out  (root),
    .side_out  (sq_side)
  );

  // stage 7: numerator sign and magnitude
  logic                  v7;
  logic                  nd7, neg7;
  logic [DV_W-1:0]       dvd7;
  logic signed [N_W-1:0] num;
  logic [N_W-1:0]        num_mag;

  always_comb begin
    num     = $signed(N_W'(root)) - N_W'($signed(sq_side[P_W-1:0]));
    num_mag = num[N_W-1] ? (~num + N_W'(1)) : num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nd7  <= sq_side[P_W];
      neg7 <= num[N_W-1] ^ a_neg;
      dvd7 <= DV_W'(num_mag) << FRAC_BITS;
    end
  end

  // divide by 2*A
  logic            dv_v;
  logic [DV_W-1:0] quo;
  logic [1:0]      dv_side;

  tte_div #(
    .DV_W   (DV_W),
    .DS_W   (DS_W),
    .SIDE_W (2)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .dividend  (dvd7),
    .divisor   ({ua, 1'b0}),
    .side_in   ({nd7, neg7}),
    .out_valid (dv_v),
    .quotient  (quo),
    .side_out  (dv_side)
  );

  // saturation, sign and status
  logic [COEF_W-1:0] limit, qsat, res_energy;
  logic [1:0]        res_status;

  always_comb begin
    limit = dv_side[0] ? (COEF_W'(1) << (COEF_W-1)) : ~(COEF_W'(1) << (COEF_W-1));
    qsat  = (quo > DV_W'(limit)) ? limit : quo[COEF_W-1:0];
    if (a_zero) begin
      res_energy = '0;
      res_status = ST_AZERO;
    end else if (dv_side[1]) begin
      res_energy = '0;
      res_status = ST_NEGDISC;
    end else begin
      res_energy = dv_side[0] ? (~qsat + COEF_W'(1)) : qsat;
      res_status = ST_OK;
    end
  end

  // output register and skid stage
  logic              out_valid;
  logic [COEF_W-1:0] out_energy, skid_energy;
  logic [1:0]        out_status, skid_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (dv_v) begin
      if (out_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_energy <= skid_energy;
        out_status <= skid_status;
      end
    end else if (dv_v) begin
      if (out_valid && !m_tready) begin
        skid_energy <= res_energy;
        skid_status <= res_status;
      end else begin
        out_energy <= res_energy;
        out_status <= res_status;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_energy;
  assign m_tuser  = out_status;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat with the output register empty");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error status with nonzero energy");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && skid_valid) |=> m_tvalid)
    else $error("skid beat lost on drain");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NEGDISC || m_tuser == ST_AZERO))
    else $error("undefined status code");

endmodule

[rtl/tte_sqrt.sv]
// ----------------------------------------------------------------------------
// tte_sqrt: pipelined integer square root
// one root bit per stage, floor(sqrt(d)), sideband carried alongside
// ----------------------------------------------------------------------------
module tte_sqrt import tte_pkg::*; #(
  parameter int D_W    = 100,
  parameter int R_W    = 50,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [D_W-1:0]    d_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [R_W-1:0]    root_out,
  output logic [SIDE_W-1:0] side_out
);

  localparam int REM_W = R_W + 3;

  logic              vld  [R_W];
  logic [D_W-1:0]    dsh  [R_W];
  logic [REM_W-1:0]  rem  [R_W];
  logic [R_W-1:0]    root [R_W];
  logic [SIDE_W-1:0] side [R_W];

  genvar k;
  for (k = 0; k < R_W; k++) begin : g_st
    logic              v_cur;
    logic [D_W-1:0]    d_cur;
    logic [REM_W-1:0]  rem_cur;
    logic [R_W-1:0]    root_cur;
    logic [SIDE_W-1:0] s_cur;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // stage input: port or previous stage
    if (k == 0) begin : g_first
      assign v_cur    = in_valid;
      assign d_cur    = d_in;
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign s_cur    = side_in;
    end else begin : g_rest
      assign v_cur    = vld[k-1];
      assign d_cur    = dsh[k-1];
      assign rem_cur  = rem[k-1];
      assign root_cur = root[k-1];
      assign s_cur    = side[k-1];
    end

    // bring in two radicand bits, try the next root bit
    always_comb begin
      rem_sh = {rem_cur[REM_W-3:0], d_cur[D_W-1 -: 2]};
      trial  = REM_W'({root_cur, 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsh[k]  <= d_cur << 2;
        rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root[k] <= {root_cur[R_W-2:0], ge};
        side[k] <= s_cur;
      end
    end
  end

  assign out_valid = vld[R_W-1];
  assign root_out  = root[R_W-1];
  assign side_out  = side[R_W-1];

endmodule

[rtl/tte_div.sv]
// ----------------------------------------------------------------------------
// tte_div: pipelined restoring divider
// one quotient bit per stage, unsigned, sideband carried alongside
// ----------------------------------------------------------------------------
module tte_div import tte_pkg::*; #(
  parameter int DV_W   = 67,
  parameter int DS_W   = 33,
  parameter int SIDE_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DV_W-1:0]   dividend,
  input  logic [DS_W-1:0]   divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [DV_W-1:0]   quotient,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld  [DV_W];
  logic [DV_W-1:0]   dvd  [DV_W];
  logic [DS_W-1:0]   dvs  [DV_W];
  logic [DS_W-1:0]   rem  [DV_W];
  logic [DV_W-1:0]   quo  [DV_W];
  logic [SIDE_W-1:0] side [DV_W];

  genvar k;
  for (k = 0; k < DV_W; k++) begin : g_st
    logic              v_cur;
    logic [DV_W-1:0]   dvd_cur;
    logic [DS_W-1:0]   dvs_cur;
    logic [DS_W-1:0]   rem_cur;
    logic [DV_W-1:0]   quo_cur;
    logic [SIDE_W-1:0] s_cur;
    logic [DS_W:0]     rem_sh;
    logic [DS_W:0]     rem_sub;
    logic              ge;

    // stage input: port or previous stage
    if (k == 0) begin : g_first
      assign v_cur   = in_valid;
      assign dvd_cur = dividend;
      assign dvs_cur = divisor;
      assign rem_cur = '0;
      assign quo_cur = '0;
      assign s_cur   = side_in;
    end else begin : g_rest
      assign v_cur   = vld[k-1];
      assign dvd_cur = dvd[k-1];
      assign dvs_cur = dvs[k-1];
      assign rem_cur = rem[k-1];
      assign quo_cur = quo[k-1];
      assign s_cur   = side[k-1];
    end

    // shift in the next dividend bit and try a subtract
    always_comb begin
      rem_sh  = {rem_cur, dvd_cur[DV_W-1]};
      ge      = (rem_sh >= {1'b0, dvs_cur});
      rem_sub = rem_sh - {1'b0, dvs_cur};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd[k]  <= dvd_cur << 1;
        dvs[k]  <= dvs_cur;
        rem[k]  <= ge ? rem_sub[DS_W-1:0] : rem_sh[DS_W-1:0];
        quo[k]  <= {quo_cur[DV_W-2:0], ge};
        side[k] <= s_cur;
      end
    end
  end

  assign out_valid = vld[DV_W-1];
  assign quotient  = quo[DV_W-1];
  assign side_out  = side[DV_W-1];

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the tot to energy calibration block
// a directed table covers reset coefficients, A of zero, negative
// discriminant, zero discriminant and saturation at both ends; random
// coefficient phases follow, each beat checked against a wide-integer model
// ----------------------------------------------------------------------------
module tb;
  import tte_pkg::*;

  localparam int TB = TOT_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IN_W = ((TB+7)/8)*8;
  localparam int DRAIN_CYCLES = 160;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [31:0] energy;
    logic [1:0]  status;
  } calib_t;

  typedef struct {
    logic [31:0] a, b, c, t;
    logic [TB-1:0] tot;
    bit           typed;
    logic [31:0]  energy;
    logic [1:0]   status;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;          // [13:0] tot_count
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [COEF_W-1:0] m_tdata;             // [31:0] energy
  logic [1:0] m_tuser;                    // [1:0] calib_status
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [COEF_W-1:0] pwdata = '0;
  logic [COEF_W-1:0] prdata;
  logic pready;

  // shadow coefficients
  logic signed [31:0] coef_a = 32'sd65536, coef_b = '0, coef_c = '0, coef_t = '0;

  calib_t energy_q[$];
  int errors = 0;
  int cycle = 0;
  int quiet = 0;

  tot_to_energy_calibration dut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // no idling in a middle stretch of the run
  function automatic bit idle_now();
    return (cycle < 1500 || cycle > 2400) && $urandom_range(99) < 12;
  endfunction

  // expected energy from the current coefficients, wide integer arithmetic
  function automatic calib_t calibrate(logic [TB-1:0] tot);
    longint a, b, c, t, pb, pc, num;
    logic signed [127:0] pbw, pcw, aw, d;
    logic [127:0] root, cand, q, mnum, lim;
    bit neg;
    calib_t r;
    a = longint'(coef_a);
    b = longint'(coef_b);
    c = longint'(coef_c);
    t = longint'(coef_t);
    if (a == 0) return '{energy: '0, status: ST_AZERO};
    pb = b - (longint'(tot) <<< FB) - ((a * t) >>> FB);
    pc = longint'(tot) * t - ((b * t) >>> FB) - c;
    pbw = pb;
    pcw = pc;
    aw = a;
    d = pbw * pbw - 4 * aw * pcw;
    if (d < 0) return '{energy: '0, status: ST_NEGDISC};
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= d) root = cand;
    end
    num = longint'(root[63:0]) - pb;
    neg = (num < 0) != (a < 0);
    mnum = (num < 0) ? 128'(-num) : 128'(num);
    q = (mnum << FB) / (128'((a < 0) ? -a : a) * 2);
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    r.energy = neg ? -q[31:0] : q[31:0];
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycle, what);
    errors++;
  endtask

  // one register write, setup then access
  task automatic write_coef(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_A: coef_a = val;
      REG_B: coef_b = val;
      REG_C: coef_c = val;
      default: coef_t = val;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait until the pipeline is empty, then rewrite any changed coefficient, or every one when all is set
  task automatic set_coefs(logic [31:0] a, b, c, t, bit all);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (energy_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (all || a != coef_a) write_coef(REG_A, a);
    if (all || b != coef_b) write_coef(REG_B, b);
    if (all || c != coef_c) write_coef(REG_C, c);
    if (all || t != coef_t) write_coef(REG_T, t);
  endtask

  // send one tot beat and record what must come back
  task automatic send_tot(logic [TB-1:0] tot, bit typed, calib_t typed_res);
    @(negedge clk);
    while (idle_now()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(tot);
    do @(posedge clk); while (!s_tready);
    energy_q.push_back(typed ? typed_res : calibrate(tot));
  endtask

  function automatic logic [31:0] pick_coef(int mode, int scale);
    logic [31:0] ext[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
    case (mode)
      0: return $urandom;
      1: return ext[$urandom_range(4)];
      default: return 32'($signed($urandom_range(2 * scale)) - scale);
    endcase
  endfunction

  // stimulus
  initial begin
    row_t rows[$];
    calib_t res;
    logic [31:0] na, nb, nc, nt;
    int mode;
    rows = '{
      '{32'h1_0000, 0, 0, 0, 14'd0,     1, 32'h0,          ST_OK},
      '{32'h1_0000, 0, 0, 0, 14'd1,     1, 32'h1_0000,     ST_OK},
      '{32'h1_0000, 0, 0, 0, 14'd16383, 1, 32'h3fff_0000,  ST_OK},
      '{32'h1_0000, 0, 0, 0, 14'h2aaa,  0, 0, ST_OK},
      '{32'h1_0000, 0, 0, 0, 14'h1555,  0, 0, ST_OK},
      '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234, 14'd5,     1, 32'h0, ST_AZERO},
      '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234, 14'd16383, 1, 32'h0, ST_AZERO},
      '{32'h1_0000, 0, 32'h8000_0000, 0, 14'd0, 1, 32'h0, ST_NEGDISC},
      '{32'h1_0000, 0, 32'h8000_0000, 0, 14'd3, 0, 0, ST_OK},
      '{32'h1, 0, 0, 0, 14'd16383, 1, 32'h7fff_ffff, ST_OK},
      '{32'h1, 0, 0, 0, 14'd0,     1, 32'h0,         ST_OK},
      '{32'hffff_ffff, 0, 0, 0, 14'd16383, 1, 32'h8000_0000, ST_OK},
      '{32'hffff_ffff, 0, 0, 0, 14'd7,     1, 32'h8000_0000, ST_OK},
      '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 14'd16383, 0, 0, ST_OK},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 14'd0,     0, 0, ST_OK},
      '{32'h1_8000, 32'h20_0000, 32'hffc0_0000, 32'h2_0000, 14'd100,  0, 0, ST_OK},
      '{32'h1_8000, 32'h20_0000, 32'hffc0_0000, 32'h2_0000, 14'd9000, 0, 0, ST_OK}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed table
    foreach (rows[i]) begin
      if (rows[i].a != coef_a || rows[i].b != coef_b ||
          rows[i].c != coef_c || rows[i].t != coef_t)
        set_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].t, 1'b0);
      res.energy = rows[i].energy;
      res.status = rows[i].status;
      send_tot(rows[i].tot, rows[i].typed, res);
    end
    // random phases, the first with extreme coefficients
    for (int ph = 0; ph < 8; ph++) begin
      mode = (ph == 0) ? 1 : $urandom_range(3);
      if (mode == 3) mode = 2;
      na = (mode == 2) ? 32'(32'sd65536 + $signed(pick_coef(2, 40000))) : pick_coef(mode, 0);
      nb = pick_coef(mode, 1 << 22);
      nc = pick_coef(mode, 1 << 24);
      nt = pick_coef(mode, 1 << 20);
      set_coefs(na, nb, nc, nt, 1'b1);
      for (int k = 0; k < 105; k++)
        send_tot(($urandom_range(3) == 0) ? TB'($urandom_range(63)) : TB'($urandom), 1'b0, res);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (energy_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // sink stalls
  always @(negedge clk) begin
    if (!rst) m_tready <= !idle_now();
  end

  // result checker and watchdog
  always @(posedge clk) begin
    calib_t exp_res;
    cycle <= cycle + 1;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (energy_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        exp_res = energy_q.pop_front();
        if (m_tdata !== exp_res.energy)
          report($sformatf("energy %h expected %h", m_tdata, exp_res.energy));
        if (m_tuser !== exp_res.status)
          report($sformatf("status %0d expected %0d", m_tuser, exp_res.status));
      end
    end
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog expired at cycle %0d", cycle);
      $display("tb failed");
      $finish;
    end
  end

endmodule
